[src/gbte_pkg.sv]
// Shared types, codes and helpers for the gap buffer text editor.
// No dependencies; every other file imports this package.
package gbte_pkg;

   localparam int CAPACITY_DEFAULT = 4096;

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;

   typedef enum logic [3:0] {
      REQ_INSERT    = 4'd0,
      REQ_DELETE    = 4'd1,
      REQ_LEFT      = 4'd2,
      REQ_RIGHT     = 4'd3,
      REQ_UP        = 4'd4,
      REQ_DOWN      = 4'd5,
      REQ_LINESTART = 4'd6,
      REQ_FIRSTNB   = 4'd7,
      REQ_LINEEND   = 4'd8,
      REQ_PREVWORD  = 4'd9,
      REQ_NEXTWORD  = 4'd10,
      REQ_WORDEND   = 4'd11,
      REQ_COLUMN    = 4'd12
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BUF_START  = 3'd1,
      ST_BUF_END    = 3'd2,
      ST_LINE_START = 3'd3,
      ST_LINE_END   = 3'd4,
      ST_FIRST_LINE = 3'd5,
      ST_LAST_LINE  = 3'd6,
      ST_FULL       = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      CLS_SPACE = 2'd0,
      CLS_WORD  = 2'd1,
      CLS_PUNCT = 2'd2
   } class_type;

   // scan predicates: what keeps a scan walking
   typedef enum logic [1:0] {
      PR_NOT_NL = 2'd0,
      PR_CLASS  = 2'd1,
      PR_SPACE  = 2'd2,
      PR_BLANK  = 2'd3
   } pred_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_EXEC,
      SQ_SCAN_RD,
      SQ_SCAN_CHK,
      SQ_READ,
      SQ_MOVE_RD,
      SQ_MOVE_WR,
      SQ_DONE
   } seq_state_type;

   typedef enum logic [3:0] {
      PH_0, PH_1, PH_2, PH_3, PH_4, PH_5, PH_6, PH_7, PH_8,
      PH_COL, PH_FIN
   } phase_type;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [7:0]  char_in;
      logic [12:0] wanted_column;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [12:0] column;
      logic [12:0] cursor_pos;
      logic [12:0] text_length;
   } rsp_word_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic class_type byte_class(input logic [7:0] c);
      if (is_space(c)) return CLS_SPACE;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A) || (c == CHAR_UNDER))
         return CLS_WORD;
      return CLS_PUNCT;
   endfunction

endpackage

[src/gbte_text_ram.sv]
// Text byte store: one write port, one read port with registered data.
// Depends on gbte_pkg only for the default capacity.
module gbte_text_ram
   import gbte_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [CAPACITY];
   logic [7:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/gap_buffer_text_editor.sv]
// Gap buffer text editor top level: command sequencer, gap and scan logic.
// Depends on gbte_pkg and gbte_text_ram.
//
//  channel | ports                       | flow
//  --------+-----------------------------+-------------------------------
//  request | start, busy, req_data       | word taken when start & !busy
//  result  | rsp_strobe, rsp_data        | one word, one cycle, no stall
//
// A command passes at least through decode, column setup, one probe of the
// closing column scan, column result and the result word. A scan reads and
// checks each byte it walks over, a gap move reads and writes each byte, on
// the single text RAM read port; a scan ends from its read or check state,
// a move from its read state; a single-byte read or extra phase adds a state.
// Reset empties the buffer at once; the RAM itself is never cleared.
// The result strobe lasts one cycle and busy drops in the next.
module gap_buffer_text_editor
   import gbte_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_strobe,
   output rsp_word_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int WW = (PW > 13) ? PW : 13;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

   seq_state_type state_ff, state_in, jump;
   phase_type     phase_ff, phase_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PW-1:0] p_ff, p_in, t_ff, t_in;
   logic [12:0]   col_ff, col_in;
   status_type    status_ff, status_in;
   logic [3:0]    cmd_ff, cmd_in;
   logic [7:0]    ch_ff, ch_in;
   logic [12:0]   want_ff, want_in;
   class_type     cls_ff, cls_in;
   pred_type      pred_ff, pred_in;
   logic          fwd_ff, fwd_in;
   logic          lo_ff, lo_in;
   logic          oob_ff;

   logic [PW-1:0] text_n, idx, head_m1, tail_m1, len, lo_pos, hi_pos, tgt;
   logic [PW:0]   phys;
   logic          oob;
   logic [7:0]    ram_q, rbyte;
   class_type     bcls;
   logic          at_bound, hit;
   logic [WW-1:0] want_x, len_x;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   gbte_text_ram #(.CAPACITY(CAPACITY)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (ram_q)
   );

   // logical to physical index mapping
   assign text_n  = head_ff + (CAP_P - tail_ff);
   assign head_m1 = head_ff - PW'(1);
   assign tail_m1 = tail_ff - PW'(1);
   assign idx     = (state_ff == SQ_SCAN_RD && !fwd_ff) ? (p_ff - PW'(1)) : p_ff;
   assign phys    = (idx < head_ff) ? {1'b0, idx}
                                    : {1'b0, idx} + {1'b0, (tail_ff - head_ff)};
   assign oob     = (phys >= {1'b0, CAP_P});
   assign rbyte   = oob_ff ? 8'h00 : ram_q;
   assign bcls    = byte_class(rbyte);

   // scan unit: bound check and predicate
   always_comb begin
      if (fwd_ff) at_bound = (p_ff >= text_n);
      else        at_bound = (p_ff <= PW'(lo_ff));
      case (pred_ff)
         PR_NOT_NL: hit = (rbyte != CHAR_NL);
         PR_CLASS:  hit = (bcls == cls_ff);
         PR_SPACE:  hit = is_space(rbyte);
         PR_BLANK:  hit = (rbyte == CHAR_SPACE) || (rbyte == CHAR_TAB);
         default:   hit = 1'b0;
      endcase
   end

   // vertical move target: line start plus clamped column
   always_comb begin
      if (cmd_ff == REQ_UP) begin
         lo_pos = p_ff;
         hi_pos = t_ff;
      end else begin
         lo_pos = t_ff;
         hi_pos = p_ff;
      end
      len    = hi_pos - lo_pos;
      len_x  = WW'(len);
      want_x = WW'(want_ff);
      tgt    = (want_x > len_x) ? hi_pos : lo_pos + PW'(want_x);
   end

   // sequencer datapath
   always_comb begin
      jump      = state_ff;
      phase_in  = phase_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      p_in      = p_ff;
      t_in      = t_ff;
      col_in    = col_ff;
      status_in = status_ff;
      cmd_in    = cmd_ff;
      ch_in     = ch_ff;
      want_in   = want_ff;
      cls_in    = cls_ff;
      pred_in   = pred_ff;
      fwd_in    = fwd_ff;
      lo_in     = lo_ff;
      mem_we    = 1'b0;
      mem_waddr = head_ff[AW-1:0];
      mem_wdata = ch_ff;
      mem_raddr = phys[AW-1:0];

      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               cmd_in    = req_data.req_type;
               ch_in     = req_data.char_in;
               want_in   = req_data.wanted_column;
               status_in = ST_OK;
               phase_in  = PH_0;
               jump      = SQ_EXEC;
            end
         end

         SQ_SCAN_RD: begin
            if (at_bound) jump = SQ_EXEC;
            else          jump = SQ_SCAN_CHK;
         end

         SQ_SCAN_CHK: begin
            if (hit) begin
               p_in = fwd_ff ? (p_ff + PW'(1)) : (p_ff - PW'(1));
               jump = SQ_SCAN_RD;
            end else begin
               jump = SQ_EXEC;
            end
         end

         SQ_READ: jump = SQ_EXEC;

         SQ_MOVE_RD: begin
            if (head_ff > t_ff) begin
               mem_raddr = head_m1[AW-1:0];
               jump      = SQ_MOVE_WR;
            end else if (head_ff < t_ff) begin
               mem_raddr = tail_ff[AW-1:0];
               jump      = SQ_MOVE_WR;
            end else begin
               jump = SQ_EXEC;
            end
         end

         // one byte crosses the gap
         SQ_MOVE_WR: begin
            mem_we    = 1'b1;
            mem_wdata = ram_q;
            if (head_ff > t_ff) begin
               mem_waddr = tail_m1[AW-1:0];
               head_in   = head_m1;
               tail_in   = tail_m1;
            end else begin
               mem_waddr = head_ff[AW-1:0];
               head_in   = head_ff + PW'(1);
               tail_in   = tail_ff + PW'(1);
            end
            jump = SQ_MOVE_RD;
         end

         SQ_DONE: jump = SQ_IDLE;

         SQ_EXEC: begin
            if (phase_ff == PH_COL) begin
               // column: scan back to the line start
               p_in = head_ff; fwd_in = 1'b0; lo_in = 1'b0; pred_in = PR_NOT_NL;
               phase_in = PH_FIN; jump = SQ_SCAN_RD;
            end else if (phase_ff == PH_FIN) begin
               col_in = 13'(head_ff - p_ff);
               jump   = SQ_DONE;
            end else begin
               phase_in = PH_COL;
               case (cmd_ff)
                  REQ_INSERT: begin
                     if (head_ff >= tail_ff) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        head_in = head_ff + PW'(1);
                     end
                  end

                  REQ_DELETE: begin
                     if (head_ff == '0) status_in = ST_BUF_START;
                     else               head_in   = head_m1;
                  end

                  REQ_LEFT: begin
                     case (phase_ff)
                        PH_0: begin
                           if (head_ff == '0) begin
                              status_in = ST_BUF_START;
                           end else begin
                              p_in = head_m1; phase_in = PH_1; jump = SQ_READ;
                           end
                        end
                        PH_1: begin
                           if (rbyte == CHAR_NL) status_in = ST_LINE_START;
                           else begin
                              t_in = head_m1; jump = SQ_MOVE_RD;
                           end
                        end
                        default: ;
                     endcase
                  end

                  REQ_RIGHT: begin
                     case (phase_ff)
                        PH_0: begin
                           if (head_ff >= text_n) begin
                              status_in = ST_BUF_END;
                           end else begin
                              p_in = head_ff; phase_in = PH_1; jump = SQ_READ;
                           end
                        end
                        PH_1: begin
                           if (rbyte == CHAR_NL) status_in = ST_LINE_END;
                           else begin
                              t_in = head_ff + PW'(1); jump = SQ_MOVE_RD;
                           end
                        end
                        default: ;
                     endcase
                  end

                  REQ_UP: begin
                     case (phase_ff)
                        PH_0: begin
                           p_in = head_ff; fwd_in = 1'b0; lo_in = 1'b0;
                           pred_in = PR_NOT_NL; phase_in = PH_1; jump = SQ_SCAN_RD;
                        end
                        PH_1: begin
                           if (p_ff == '0) begin
                              status_in = ST_FIRST_LINE;
                           end else begin
                              t_in = p_ff - PW'(1); p_in = p_ff - PW'(1);
                              fwd_in = 1'b0; lo_in = 1'b0; pred_in = PR_NOT_NL;
                              phase_in = PH_2; jump = SQ_SCAN_RD;
                           end
                        end
                        PH_2: begin
                           t_in = tgt; jump = SQ_MOVE_RD;
                        end
                        default: ;
                     endcase
                  end

                  REQ_DOWN: begin
                     case (phase_ff)
                        PH_0: begin
                           p_in = head_ff; fwd_in = 1'b1; lo_in = 1'b0;
                           pred_in = PR_NOT_NL; phase_in = PH_1; jump = SQ_SCAN_RD;
                        end
                        PH_1: begin
                           if (p_ff == text_n) begin
                              status_in = ST_LAST_LINE;
                           end else begin
                              t_in = p_ff + PW'(1); p_in = p_ff + PW'(1);
                              fwd_in = 1'b1; pred_in = PR_NOT_NL;
                              phase_in = PH_2; jump = SQ_SCAN_RD;
                           end
                        end
                        PH_2: begin
                           t_in = tgt; jump = SQ_MOVE_RD;
                        end
                        default: ;
                     endcase
                  end

                  REQ_LINESTART, REQ_LINEEND: begin
                     case (phase_ff)
                        PH_0: begin
                           p_in = head_ff; fwd_in = (cmd_ff == REQ_LINEEND);
                           lo_in = 1'b0; pred_in = PR_NOT_NL;
                           phase_in = PH_1; jump = SQ_SCAN_RD;
                        end
                        PH_1: begin
                           t_in = p_ff; jump = SQ_MOVE_RD;
                        end
                        default: ;
                     endcase
                  end

                  REQ_FIRSTNB: begin
                     case (phase_ff)
                        PH_0: begin
                           p_in = head_ff; fwd_in = 1'b0; lo_in = 1'b0;
                           pred_in = PR_NOT_NL; phase_in = PH_1; jump = SQ_SCAN_RD;
                        end
                        PH_1: begin
                           t_in = p_ff; phase_in = PH_2; jump = SQ_MOVE_RD;
                        end
                        PH_2: begin
                           p_in = head_ff; fwd_in = 1'b1; pred_in = PR_BLANK;
                           phase_in = PH_3; jump = SQ_SCAN_RD;
                        end
                        PH_3: begin
                           if (p_ff < text_n) begin
                              phase_in = PH_4; jump = SQ_READ;
                           end
                        end
                        PH_4: begin
                           if (rbyte != CHAR_NL) begin
                              t_in = p_ff; jump = SQ_MOVE_RD;
                           end
                        end
                        default: ;
                     endcase
                  end

                  REQ_PREVWORD: begin
                     case (phase_ff)
                        PH_0: begin
                           if (head_ff != '0) begin
                              // skip spaces back, never below index zero
                              p_in = head_ff; fwd_in = 1'b0; lo_in = 1'b1;
                              pred_in = PR_SPACE; phase_in = PH_1; jump = SQ_SCAN_RD;
                           end
                        end
                        PH_1: begin
                           p_in = p_ff - PW'(1); phase_in = PH_2; jump = SQ_READ;
                        end
                        PH_2: begin
                           if (bcls != CLS_SPACE) begin
                              cls_in = bcls; fwd_in = 1'b0; lo_in = 1'b0;
                              pred_in = PR_CLASS; phase_in = PH_3; jump = SQ_SCAN_RD;
                           end else begin
                              t_in = p_ff; jump = SQ_MOVE_RD;
                           end
                        end
                        PH_3: begin
                           t_in = p_ff; jump = SQ_MOVE_RD;
                        end
                        default: ;
                     endcase
                  end

                  REQ_NEXTWORD: begin
                     case (phase_ff)
                        PH_0: begin
                           if (head_ff < text_n) begin
                              p_in = head_ff; phase_in = PH_1; jump = SQ_READ;
                           end
                        end
                        PH_1: begin
                           phase_in = PH_2;
                           if (bcls != CLS_SPACE) begin
                              cls_in = bcls; fwd_in = 1'b1; pred_in = PR_CLASS;
                              jump = SQ_SCAN_RD;
                           end
                        end
                        PH_2: begin
                           fwd_in = 1'b1; pred_in = PR_SPACE;
                           phase_in = PH_3; jump = SQ_SCAN_RD;
                        end
                        PH_3: begin
                           t_in = p_ff; jump = SQ_MOVE_RD;
                        end
                        default: ;
                     endcase
                  end

                  REQ_WORDEND: begin
                     case (phase_ff)
                        PH_0: begin
                           p_in = head_ff;
                           if (head_ff < text_n) begin
                              phase_in = PH_1; jump = SQ_READ;
                           end else begin
                              phase_in = PH_3;
                           end
                        end
                        PH_1: begin
                           cls_in   = bcls;
                           phase_in = PH_3;
                           if (bcls != CLS_SPACE) begin
                              p_in = head_ff + PW'(1);
                              if (head_ff + PW'(1) < text_n) begin
                                 phase_in = PH_2; jump = SQ_READ;
                              end
                           end
                        end
                        PH_2: begin
                           // a run of one byte steps past it first
                           if (bcls == cls_ff) p_in = head_ff;
                           phase_in = PH_3;
                        end
                        PH_3: begin
                           fwd_in = 1'b1; pred_in = PR_SPACE;
                           phase_in = PH_4; jump = SQ_SCAN_RD;
                        end
                        PH_4: begin
                           if (p_ff < text_n) begin
                              phase_in = PH_5; jump = SQ_READ;
                           end
                        end
                        PH_5: begin
                           phase_in = PH_6;
                           if (bcls != CLS_SPACE) begin
                              cls_in = bcls; fwd_in = 1'b1; pred_in = PR_CLASS;
                              jump = SQ_SCAN_RD;
                           end
                        end
                        PH_6: begin
                           t_in = p_ff; phase_in = PH_7; jump = SQ_MOVE_RD;
                        end
                        PH_7: begin
                           if (head_ff != '0) begin
                              p_in = head_m1; phase_in = PH_8; jump = SQ_READ;
                           end
                        end
                        PH_8: begin
                           if (rbyte != CHAR_NL) begin
                              t_in = head_m1; jump = SQ_MOVE_RD;
                           end
                        end
                        default: ;
                     endcase
                  end

                  default: ;
               endcase
               // gap targets never pass the text end
               if (jump == SQ_MOVE_RD && t_in > text_n) t_in = text_n;
            end
         end

         default: jump = SQ_IDLE;
      endcase
   end

   // next state
   always_comb begin
      state_in = jump;
   end

   // outputs
   always_comb begin
      busy                 = (state_ff != SQ_IDLE);
      rsp_strobe           = (state_ff == SQ_DONE);
      rsp_data.status      = status_ff;
      rsp_data.column      = col_ff;
      rsp_data.cursor_pos  = 13'(head_ff);
      rsp_data.text_length = 13'(text_n);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         phase_ff <= PH_0;
         head_ff  <= '0;
         tail_ff  <= CAP_P;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      t_ff      <= t_in;
      col_ff    <= col_in;
      status_ff <= status_in;
      cmd_ff    <= cmd_in;
      ch_ff     <= ch_in;
      want_ff   <= want_in;
      cls_ff    <= cls_in;
      pred_ff   <= pred_in;
      fwd_ff    <= fwd_in;
      lo_ff     <= lo_in;
      oob_ff    <= oob;
   end

   // gap never inverts
   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("gap head passed gap tail");

   // tail stays inside the store
   a_tail_range: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= CAP_P) else $error("gap tail beyond capacity");

   // result word is a single-cycle pulse and ends the command
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy) else $error("result strobe held");

   // an accepted command makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("command accepted but not busy");

   // gap moves change head and tail in step
   a_move_lockstep: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_MOVE_WR |=> (head_ff - $past(head_ff)) == (tail_ff - $past(tail_ff)))
      else $error("gap move out of step");

endmodule

[tb/gap_buffer_text_editor_tb.sv]
// Self-checking testbench for gap_buffer_text_editor: directed table, then
// random edit traffic, checked against an in-bench gap buffer model or pinned words.
// Depends on gbte_pkg and the gap_buffer_text_editor RTL.
`timescale 1ns / 100ps

module gap_buffer_text_editor_tb;
   import gbte_pkg::*;

   localparam int CAP = CAPACITY_DEFAULT;
   localparam logic [3:0] REQ_UNUSED = 4'd15;
   localparam int RANDOM_WORDS = 420;
   localparam int QUIET_TAIL = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_data = '0;
   logic rsp_strobe;
   rsp_word_type rsp_data;

   gap_buffer_text_editor u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow gap buffer
   logic [7:0] shadow_text [CAP];
   int gap_lo = 0;
   int gap_hi = CAP;

   rsp_word_type expected_rsp_q [$];
   int mismatch_count = 0;
   int words_checked = 0;

   // per-word check mode set by the driver
   logic pin_result = 1'b0;
   rsp_word_type pinned_rsp = '0;

   function automatic int text_len();
      return gap_lo + (CAP - gap_hi);
   endfunction

   function automatic logic [7:0] char_at(int i);
      int p;
      p = (i < gap_lo) ? i : i + (gap_hi - gap_lo);
      if (p >= CAP) return 8'h00;
      return shadow_text[p];
   endfunction

   function automatic logic blank(logic [7:0] c);
      return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic class_type char_class(logic [7:0] c);
      if (blank(c)) return CLS_SPACE;
      if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
          c == CHAR_UNDER)
         return CLS_WORD;
      return CLS_PUNCT;
   endfunction

   function automatic int sol(int p);
      while (p > 0 && char_at(p - 1) != CHAR_NL) p--;
      return p;
   endfunction

   function automatic int eol(int p);
      while (p < text_len() && char_at(p) != CHAR_NL) p++;
      return p;
   endfunction

   function automatic void shift_gap(int t);
      if (t > text_len()) t = text_len();
      while (gap_lo > t) begin
         gap_hi--; gap_lo--;
         shadow_text[gap_hi] = shadow_text[gap_lo];
      end
      while (gap_lo < t) begin
         shadow_text[gap_lo] = shadow_text[gap_hi];
         gap_lo++; gap_hi++;
      end
   endfunction

   function automatic int run_back(int p, class_type c);
      while (p > 0 && char_class(char_at(p - 1)) == c) p--;
      return p;
   endfunction

   function automatic int run_fwd(int p, class_type c);
      while (p < text_len() && char_class(char_at(p)) == c) p++;
      return p;
   endfunction

   function automatic int past_blanks(int p);
      while (p < text_len() && blank(char_at(p))) p++;
      return p;
   endfunction

   function automatic status_type move_vertical(logic up, int want);
      int s, e, ls;
      if (up) begin
         ls = sol(gap_lo);
         if (ls == 0) return ST_FIRST_LINE;
         e = ls - 1;
         s = sol(e);
      end else begin
         ls = eol(gap_lo);
         if (ls == text_len()) return ST_LAST_LINE;
         s = ls + 1;
         e = eol(s);
      end
      if (want > e - s) want = e - s;
      shift_gap(s + want);
      return ST_OK;
   endfunction

   function automatic void to_word_end();
      int n, t;
      class_type c;
      logic same;
      n = text_len();
      t = gap_lo;
      if (t < n) begin
         c = char_class(char_at(t));
         same = (t + 1 < n) && char_class(char_at(t + 1)) == c;
         if (c != CLS_SPACE && !same) t++;
      end
      t = past_blanks(t);
      if (t >= n) return;
      c = char_class(char_at(t));
      if (c != CLS_SPACE) t = run_fwd(t, c);
      shift_gap(t);
      if (gap_lo > 0 && char_at(gap_lo - 1) != CHAR_NL) shift_gap(gap_lo - 1);
   endfunction

   // apply one command word to the shadow buffer and return the result word
   function automatic rsp_word_type edit_step(req_word_type w);
      status_type st;
      int n, t;
      class_type c;
      rsp_word_type r;
      st = ST_OK;
      n = text_len();
      case (w.req_type)
         REQ_INSERT:
            if (gap_lo >= gap_hi) st = ST_FULL;
            else begin
               shadow_text[gap_lo] = w.char_in;
               gap_lo++;
            end
         REQ_DELETE:
            if (gap_lo == 0) st = ST_BUF_START;
            else gap_lo--;
         REQ_LEFT:
            if (gap_lo == 0) st = ST_BUF_START;
            else if (char_at(gap_lo - 1) == CHAR_NL) st = ST_LINE_START;
            else shift_gap(gap_lo - 1);
         REQ_RIGHT:
            if (gap_lo >= n) st = ST_BUF_END;
            else if (char_at(gap_lo) == CHAR_NL) st = ST_LINE_END;
            else shift_gap(gap_lo + 1);
         REQ_UP: st = move_vertical(1'b1, int'(w.wanted_column));
         REQ_DOWN: st = move_vertical(1'b0, int'(w.wanted_column));
         REQ_LINESTART: shift_gap(sol(gap_lo));
         REQ_FIRSTNB: begin
            shift_gap(sol(gap_lo));
            t = gap_lo;
            while (t < n && (char_at(t) == CHAR_SPACE || char_at(t) == CHAR_TAB)) t++;
            if (t < n && char_at(t) != CHAR_NL) shift_gap(t);
         end
         REQ_LINEEND: shift_gap(eol(gap_lo));
         REQ_PREVWORD:
            if (gap_lo > 0) begin
               t = gap_lo - 1;
               while (t > 0 && blank(char_at(t))) t--;
               c = char_class(char_at(t));
               if (c != CLS_SPACE) t = run_back(t, c);
               shift_gap(t);
            end
         REQ_NEXTWORD:
            if (gap_lo < n) begin
               t = gap_lo;
               c = char_class(char_at(t));
               if (c != CLS_SPACE) t = run_fwd(t, c);
               shift_gap(past_blanks(t));
            end
         REQ_WORDEND: to_word_end();
         default: ;
      endcase
      r.status = st;
      r.column = 13'(gap_lo - sol(gap_lo));
      r.cursor_pos = 13'(gap_lo);
      r.text_length = 13'(text_len());
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("%0t ERROR %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // accept side and result side, sampled at the rising edge
   always @(posedge clock) begin
      rsp_word_type p, e;
      if (!reset) begin
         if (start && !busy) begin
            p = edit_step(req_data);
            expected_rsp_q.push_back(pin_result ? pinned_rsp : p);
         end
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) report_mismatch("result with none pending", 1, 0);
            else begin
               e = expected_rsp_q.pop_front();
               words_checked++;
               if (rsp_data.status != e.status)
                  report_mismatch("status", rsp_data.status, e.status);
               if (rsp_data.column != e.column)
                  report_mismatch("column", rsp_data.column, e.column);
               if (rsp_data.cursor_pos != e.cursor_pos)
                  report_mismatch("cursor_pos", rsp_data.cursor_pos, e.cursor_pos);
               if (rsp_data.text_length != e.text_length)
                  report_mismatch("text_length", rsp_data.text_length, e.text_length);
            end
         end
      end
   end

   // present one word, hold until taken, optionally idle afterward
   task automatic send_word(logic [3:0] code, logic [7:0] ch, logic [12:0] want,
                            logic pin, rsp_word_type pinned, logic may_idle);
      req_data = '{req_type: code, char_in: ch, wanted_column: want};
      pin_result = pin;
      pinned_rsp = pinned;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   typedef struct {
      logic [3:0]   code;
      logic [7:0]   ch;
      logic [12:0]  want;
      logic         pin;
      rsp_word_type rsp;
   } dir_row_type;

   localparam rsp_word_type R_START = '{ST_BUF_START, 13'd0, 13'd0, 13'd0};
   localparam rsp_word_type R_NONE  = '{ST_OK, 13'd0, 13'd0, 13'd0};

   dir_row_type dir_rows [] = '{
      '{REQ_DELETE,    8'h00, 13'd0,    1'b1, R_START},
      '{REQ_LEFT,      8'h00, 13'd0,    1'b1, R_START},
      '{REQ_RIGHT,     8'h00, 13'd0,    1'b1, '{ST_BUF_END, 13'd0, 13'd0, 13'd0}},
      '{REQ_UP,        8'h00, 13'd5,    1'b1, '{ST_FIRST_LINE, 13'd0, 13'd0, 13'd0}},
      '{REQ_DOWN,      8'h00, 13'd5,    1'b1, '{ST_LAST_LINE, 13'd0, 13'd0, 13'd0}},
      '{REQ_PREVWORD,  8'h00, 13'd0,    1'b1, R_NONE},
      '{REQ_NEXTWORD,  8'h00, 13'd0,    1'b1, R_NONE},
      '{REQ_WORDEND,   8'h00, 13'd0,    1'b1, R_NONE},
      '{REQ_UNUSED,    8'hFF, 13'h1FFF, 1'b1, R_NONE},
      '{REQ_INSERT,    "a",   13'd0,    1'b1, '{ST_OK, 13'd1, 13'd1, 13'd1}},
      '{REQ_INSERT,    8'hFF, 13'd0,    1'b0, R_NONE},
      '{REQ_INSERT,    CHAR_NL, 13'd0,  1'b0, R_NONE},
      '{REQ_INSERT,    CHAR_TAB, 13'd0, 1'b0, R_NONE},
      '{REQ_INSERT,    CHAR_SPACE, 13'd0, 1'b0, R_NONE},
      '{REQ_INSERT,    CHAR_UNDER, 13'd0, 1'b0, R_NONE},
      '{REQ_INSERT,    8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_INSERT,    CHAR_NL, 13'd0,  1'b0, R_NONE},
      '{REQ_INSERT,    "x",   13'd0,    1'b0, R_NONE},
      '{REQ_UP,        8'h00, 13'h1FFF, 1'b0, R_NONE},
      '{REQ_FIRSTNB,   8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_LINESTART, 8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_LEFT,      8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_RIGHT,     8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_LINEEND,   8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_RIGHT,     8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_DOWN,      8'h00, 13'd4096, 1'b0, R_NONE},
      '{REQ_PREVWORD,  8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_WORDEND,   8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_NEXTWORD,  8'h00, 13'd0,    1'b0, R_NONE},
      '{REQ_COLUMN,    8'h00, 13'd0,    1'b0, R_NONE}
   };

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'($urandom_range("a", "z"));
         3: return 8'($urandom_range("0", "9"));
         4: return CHAR_SPACE;
         5: return CHAR_NL;
         6: return CHAR_TAB;
         7: return CHAR_UNDER;
         8: return 8'($urandom_range(8'h21, 8'h2F));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [12:0] pick_column();
      case ($urandom_range(0, 9))
         0: return 13'd4096;
         1: return 13'($urandom);
         default: return 13'($urandom_range(0, 20));
      endcase
   endfunction

   // stimulus
   initial begin
      logic [3:0] code;
      int j;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (dir_rows[i])
         send_word(dir_rows[i].code, dir_rows[i].ch, dir_rows[i].want,
                   dir_rows[i].pin, dir_rows[i].rsp, 1'b1);

      // random edits, text kept short so scans stay cheap
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         j = $urandom_range(0, 99);
         if (j < 40) code = REQ_INSERT;
         else if (j < 48) code = REQ_DELETE;
         else if (j < 96) code = 4'($urandom_range(REQ_LEFT, REQ_COLUMN));
         else code = 4'($urandom_range(13, 15));
         if (code == REQ_INSERT && text_len() > 200) code = REQ_DELETE;
         send_word(code, pick_char(), pick_column(), 1'b0, R_NONE,
                   k < RANDOM_WORDS - QUIET_TAIL);
      end
      start = 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Checked %0d result words: directed edge cases on an empty and short buffer",
               words_checked);
      $display("and %0d random edit and cursor commands with random idle bursts.",
               RANDOM_WORDS);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(60_000_000);
      $display("Timeout with %0d results pending", expected_rsp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
